FILE: hdl/rst_pkg.sv
// ----------------------------------------------------------------------------
// rst_pkg - shared types and constants for the session tracker
// Slot table geometry, request codes and result codes.
// ----------------------------------------------------------------------------
`default_nettype none
package rst_pkg;
    localparam int unsigned PoolDepth = 256;
    localparam int unsigned SlotBits  = 8;
    localparam int unsigned SeqBits   = 48;
    localparam int unsigned MaxEndpoints = 65536;
    // packed slot entry: total(17) pos(16) method(16) ident(64)
    localparam int unsigned EntryW = 64 + 16 + 16 + 17;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_FAILED  = 2'd1,
        REQ_RESP    = 2'd2,
        REQ_TIMEOUT = 2'd3
    } t_req;

    localparam logic [1:0] DONE_INTERNAL = 2'd0;
    localparam logic [1:0] DONE_TIMEOUT  = 2'd1;
    localparam logic [1:0] DONE_COMPLETE = 2'd2;

    localparam logic KIND_SEND = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [0:0] CFG_CORE = 1'b0;
    localparam logic [0:0] CFG_SEED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_EVAL,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

FILE: hdl/rpc_session_tracker.sv
// ----------------------------------------------------------------------------
// rpc_session_tracker - outstanding request session table
// Slot table in one RAM, read-modify-write sequencer.
// ----------------------------------------------------------------------------
// After reset the table is cleared by a pass over all 256 slots, one slot
// per cycle, during which no item is taken. Each item then passes through
// accept, read, evaluate and write/output. An add with more than 65536
// endpoints is dropped at accept. An add repeats read and evaluate for each
// occupied or zero id it probes, up to 256 probes, all through the single
// RAM port. A result still waiting in the output register holds the next
// item in its write/output cycle until the receiver takes it.
`default_nettype none
module rpc_session_tracker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [63:0] request_id, [79:64] method_tag, [96:80] endpoint_count,
    // [104:97] response_code, [105] response_valid, [113:106] slot_index,
    // [119:114] zero
    input  wire logic [119:0] s_axis_tdata,
    input  wire logic [1:0]   s_axis_tuser,   // [1:0] req_type
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] session_id, [79:64] endpoint, [81:80] done_status,
    // [89:82] completion_code, [97:90] slot_number, [103:98] zero
    output logic      [103:0] m_axis_tdata,
    output logic              m_axis_tuser,   // [0] result_kind
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [31:0]  i_cfg_wdata
);
    rst_pkg::t_state r_state, n_state;
    rst_pkg::t_req   r_type;
    logic [63:0] r_rid;
    logic [15:0] r_tag;
    logic [16:0] r_count;
    logic [7:0]  r_code;
    logic        r_valid;
    logic [7:0]  r_sidx;
    logic [15:0] r_core;
    logic [31:0] r_seed;
    logic [63:0] r_next_id, n_next_id;
    logic [8:0]  r_probes, n_probes;
    logic [rst_pkg::SlotBits-1:0] r_clr, n_clr;
    logic [63:0] r_cand, n_cand;
    logic        r_ovalid, n_ovalid;
    logic [103:0] r_odata, n_odata;
    logic        r_okind, n_okind;

    logic        ram_we;
    logic [rst_pkg::SlotBits-1:0] ram_addr;
    logic [rst_pkg::SlotBits-1:0] cur_addr;
    logic [rst_pkg::EntryW-1:0] ram_wdata, ram_rdata;
    logic [63:0] e_ident;
    logic [15:0] e_method, e_pos;
    logic [16:0] e_total;
    logic [16:0] nxt_pos;
    logic        out_free;

    assign e_ident  = ram_rdata[63:0];
    assign e_method = ram_rdata[79:64];
    assign e_pos    = ram_rdata[95:80];
    assign e_total  = ram_rdata[112:96];
    assign nxt_pos  = {1'b0, e_pos} + 17'd1;
    assign out_free = !r_ovalid || m_axis_tready;

    // slot of the item in hand, once the candidate id is registered
    assign cur_addr = (r_type == rst_pkg::REQ_ADD) ? r_cand[rst_pkg::SlotBits-1:0] :
                      (r_type == rst_pkg::REQ_TIMEOUT) ? r_sidx :
                      r_rid[rst_pkg::SlotBits-1:0];

    rst_ram #(.WIDTH(rst_pkg::EntryW), .DEPTH(rst_pkg::PoolDepth)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign s_axis_tready = (r_state == rst_pkg::ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_okind;

    function automatic logic [103:0] pack_out(input logic [63:0] id, input logic [15:0] ep,
                                               input logic [1:0] st, input logic [7:0] cd,
                                               input logic [7:0] sl);
        pack_out = {6'd0, sl, cd, st, ep, id};
    endfunction

    always_comb begin
        n_state   = r_state;
        n_next_id = r_next_id;
        n_probes  = r_probes;
        n_clr     = r_clr;
        n_cand    = r_cand;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_odata   = r_odata;
        n_okind   = r_okind;
        ram_we    = 1'b0;
        ram_addr  = '0;
        ram_wdata = '0;
        unique case (r_state)
            rst_pkg::ST_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = rst_pkg::ST_IDLE;
                end
            end
            rst_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_probes = '0;
                    n_state  = rst_pkg::ST_READ;
                    if (s_axis_tuser == rst_pkg::REQ_ADD
                        && s_axis_tdata[96:80] > 17'(rst_pkg::MaxEndpoints)) begin
                        n_state = rst_pkg::ST_IDLE;
                    end
                end
            end
            rst_pkg::ST_READ: begin
                if (r_type == rst_pkg::REQ_ADD) begin
                    n_cand    = r_next_id;
                    n_next_id = r_next_id + 64'd1;
                    ram_addr  = r_next_id[rst_pkg::SlotBits-1:0];
                    n_probes  = r_probes + 9'd1;
                end else if (r_type == rst_pkg::REQ_TIMEOUT) begin
                    ram_addr = r_sidx;
                end else begin
                    ram_addr = r_rid[rst_pkg::SlotBits-1:0];
                end
                n_state = rst_pkg::ST_EVAL;
            end
            rst_pkg::ST_EVAL: begin
                // keep the same slot on the RAM output for the next cycle
                ram_addr = cur_addr;
                n_state  = rst_pkg::ST_OUT;
                if (r_type == rst_pkg::REQ_ADD && !(r_cand != 64'd0 && e_ident == 64'd0)) begin
                    n_state = (r_probes == 9'(rst_pkg::PoolDepth)) ? rst_pkg::ST_OUT
                                                                    : rst_pkg::ST_READ;
                end
            end
            rst_pkg::ST_OUT: begin
                // entry data is still held on the RAM output (same slot re-read)
                if (out_free) begin
                    n_state = rst_pkg::ST_IDLE;
                    unique case (r_type)
                        rst_pkg::REQ_ADD: begin
                            n_ovalid = 1'b1;
                            if (r_cand != 64'd0 && e_ident == 64'd0) begin
                                ram_we    = 1'b1;
                                ram_addr  = r_cand[rst_pkg::SlotBits-1:0];
                                ram_wdata = {r_count, 16'd0, r_tag, r_cand};
                                n_okind   = rst_pkg::KIND_SEND;
                                n_odata   = pack_out(r_cand, 16'd0, 2'd0, 8'd0, r_cand[7:0]);
                            end else begin
                                n_okind = rst_pkg::KIND_DONE;
                                n_odata = pack_out(64'd0, 16'd0, rst_pkg::DONE_INTERNAL,
                                                   8'd0, 8'd0);
                            end
                        end
                        rst_pkg::REQ_TIMEOUT: begin
                            if (e_ident != 64'd0) begin
                                ram_we    = 1'b1;
                                ram_addr  = r_sidx;
                                ram_wdata = {ram_rdata[rst_pkg::EntryW-1:64], 64'd0};
                                n_ovalid  = 1'b1;
                                n_okind   = rst_pkg::KIND_DONE;
                                n_odata   = pack_out(e_ident, 16'd0, rst_pkg::DONE_TIMEOUT,
                                                     8'd0, r_sidx);
                            end
                        end
                        rst_pkg::REQ_FAILED: begin
                            if (r_rid != 64'd0 && e_ident == r_rid) begin
                                ram_we   = 1'b1;
                                ram_addr = r_rid[rst_pkg::SlotBits-1:0];
                                n_ovalid = 1'b1;
                                if (nxt_pos < e_total) begin
                                    ram_wdata = {e_total, nxt_pos[15:0], e_method, e_ident};
                                    n_okind   = rst_pkg::KIND_SEND;
                                    n_odata   = pack_out(r_rid, nxt_pos[15:0], 2'd0, 8'd0,
                                                         r_rid[7:0]);
                                end else begin
                                    ram_wdata = {e_total, e_pos, e_method, 64'd0};
                                    n_okind   = rst_pkg::KIND_DONE;
                                    n_odata   = pack_out(r_rid, 16'd0, rst_pkg::DONE_TIMEOUT,
                                                         8'd0, r_rid[7:0]);
                                end
                            end
                        end
                        rst_pkg::REQ_RESP: begin
                            if (r_rid != 64'd0 && e_ident == r_rid && e_method == r_tag
                                && r_valid) begin
                                ram_we    = 1'b1;
                                ram_addr  = r_rid[rst_pkg::SlotBits-1:0];
                                ram_wdata = {e_total, e_pos, e_method, 64'd0};
                                n_ovalid  = 1'b1;
                                n_okind   = rst_pkg::KIND_DONE;
                                n_odata   = pack_out(r_rid, 16'd0, rst_pkg::DONE_COMPLETE,
                                                     r_code, r_rid[7:0]);
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    // hold the RAM output: re-read the same slot
                    ram_addr = cur_addr;
                end
            end
            default: n_state = rst_pkg::ST_IDLE;
        endcase
        if (i_cfg_we) begin
            n_next_id = ({48'd0, (i_cfg_index == rst_pkg::CFG_CORE ? i_cfg_wdata[15:0] : r_core)}
                         + 64'd1) << rst_pkg::SeqBits;
            n_next_id = n_next_id + ({32'd0, (i_cfg_index == rst_pkg::CFG_SEED ? i_cfg_wdata
                                              : r_seed)} << (rst_pkg::SeqBits - 32));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rst_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_ovalid  <= 1'b0;
            r_core    <= '0;
            r_seed    <= '0;
            r_next_id <= 64'd1 << rst_pkg::SeqBits;
            r_probes  <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_ovalid  <= n_ovalid;
            r_next_id <= n_next_id;
            r_probes  <= n_probes;
            if (i_cfg_we && i_cfg_index == rst_pkg::CFG_CORE) begin
                r_core <= i_cfg_wdata[15:0];
            end
            if (i_cfg_we && i_cfg_index == rst_pkg::CFG_SEED) begin
                r_seed <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand  <= n_cand;
        r_odata <= n_odata;
        r_okind <= n_okind;
        if (s_axis_tvalid && s_axis_tready) begin
            r_type  <= rst_pkg::t_req'(s_axis_tuser);
            r_rid   <= s_axis_tdata[63:0];
            r_tag   <= s_axis_tdata[79:64];
            r_count <= s_axis_tdata[96:80];
            r_code  <= s_axis_tdata[104:97];
            r_valid <= s_axis_tdata[105];
            r_sidx  <= s_axis_tdata[113:106];
        end
    end
endmodule
`default_nettype wire

FILE: hdl/rst_ram.sv
// ----------------------------------------------------------------------------
// rst_ram - generic single-port synchronous RAM
// One address per cycle, always read and optionally written; read data registered (old data on a write).
// ----------------------------------------------------------------------------
`default_nettype none
module rst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

FILE: sim/tb_rpc_session_tracker.sv
// ----------------------------------------------------------------------------
// tb_rpc_session_tracker - self-checking bench for the session tracker
// Predicts each result from a behavioural copy of the slot table and checks
// every output item in order, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rpc_session_tracker;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] rid;
        logic [15:0] tag;
        logic [16:0] count;
        logic [7:0]  code;
        logic        valid;
        logic [7:0]  slot;
    } t_event;

    typedef struct packed {
        logic        kind;
        logic [63:0] id;
        logic [15:0] ep;
        logic [1:0]  status;
        logic [7:0]  code;
        logic [7:0]  slot;
    } t_outcome;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we;
    logic         i_cfg_index;
    logic [31:0]  i_cfg_wdata;

    rpc_session_tracker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // predictor state
    logic [63:0] tbl_ident [rst_pkg::PoolDepth];
    logic [15:0] tbl_method [rst_pkg::PoolDepth];
    logic [15:0] tbl_pos [rst_pkg::PoolDepth];
    logic [16:0] tbl_total [rst_pkg::PoolDepth];
    logic [63:0] id_ctr;
    logic [15:0] core_reg;
    logic [31:0] seed_reg;

    t_event   pending_events[$];
    t_outcome expected_outcomes[$];
    int       n_errors;
    bit       hold_rx;
    bit       hold_tx;
    int       idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reload_ctr();
        id_ctr = ({48'd0, core_reg} + 64'd1 << rst_pkg::SeqBits)
                 + ({32'd0, seed_reg} << (rst_pkg::SeqBits - 32));
    endfunction

    task automatic predict_event(input t_event e);
        t_outcome o;
        logic [63:0] cand;
        logic [7:0]  s;
        logic [16:0] nxt;
        o = '0;
        case (rst_pkg::t_req'(e.kind))
            rst_pkg::REQ_ADD: begin
                if (e.count > rst_pkg::MaxEndpoints) return;
                for (int i = 0; i < rst_pkg::PoolDepth; i++) begin
                    cand = id_ctr;
                    id_ctr = id_ctr + 64'd1;
                    s = cand[7:0];
                    if (cand != 0 && tbl_ident[s] == 0) begin
                        tbl_ident[s] = cand;
                        tbl_method[s] = e.tag;
                        tbl_pos[s] = '0;
                        tbl_total[s] = e.count;
                        o.kind = rst_pkg::KIND_SEND; o.id = cand; o.slot = s;
                        expected_outcomes.push_back(o);
                        return;
                    end
                end
                o.kind = rst_pkg::KIND_DONE; o.status = rst_pkg::DONE_INTERNAL;
                expected_outcomes.push_back(o);
            end
            rst_pkg::REQ_TIMEOUT: begin
                s = e.slot;
                if (tbl_ident[s] == 0) return;
                o.kind = rst_pkg::KIND_DONE; o.id = tbl_ident[s];
                o.status = rst_pkg::DONE_TIMEOUT; o.slot = s;
                tbl_ident[s] = '0;
                expected_outcomes.push_back(o);
            end
            default: begin
                s = e.rid[7:0];
                if (e.rid == 0 || tbl_ident[s] != e.rid) return;
                o.id = e.rid; o.slot = s;
                if (rst_pkg::t_req'(e.kind) == rst_pkg::REQ_FAILED) begin
                    nxt = {1'b0, tbl_pos[s]} + 17'd1;
                    if (nxt < tbl_total[s]) begin
                        tbl_pos[s] = nxt[15:0];
                        o.kind = rst_pkg::KIND_SEND; o.ep = nxt[15:0];
                    end else begin
                        o.kind = rst_pkg::KIND_DONE; o.status = rst_pkg::DONE_TIMEOUT;
                        tbl_ident[s] = '0;
                    end
                end else begin
                    if (tbl_method[s] != e.tag || !e.valid) return;
                    o.kind = rst_pkg::KIND_DONE; o.status = rst_pkg::DONE_COMPLETE;
                    o.code = e.code;
                    tbl_ident[s] = '0;
                end
                expected_outcomes.push_back(o);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        n_errors++;
    endtask

    // driver: bursts and gaps
    int burst_left;
    int gap_left;
    t_event cur;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_event(cur);
            if (s_axis_tvalid && !s_axis_tready) begin
                // hold the offered item
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_events.size() > 0 && !hold_tx) begin
                cur = pending_events.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= cur.kind;
                s_axis_tdata <= {6'd0, cur.slot, cur.valid, cur.code, cur.count, cur.tag, cur.rid};
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    int rx_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_phase <= 0;
        end else begin
            rx_phase <= rx_phase + 1;
            if (hold_rx) m_axis_tready <= 1'b0;
            else if (rx_phase[9:8] == 2'd3) m_axis_tready <= 1'b1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    t_outcome want;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
            end else begin
                want = expected_outcomes.pop_front();
                if (m_axis_tuser !== want.kind) report_mismatch("kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[63:0] !== want.id)
                    report_mismatch("session_id", m_axis_tdata[63:0], want.id);
                if (m_axis_tdata[79:64] !== want.ep)
                    report_mismatch("endpoint", m_axis_tdata[79:64], want.ep);
                if (m_axis_tdata[81:80] !== want.status)
                    report_mismatch("status", m_axis_tdata[81:80], want.status);
                if (m_axis_tdata[89:82] !== want.code)
                    report_mismatch("code", m_axis_tdata[89:82], want.code);
                if (m_axis_tdata[97:90] !== want.slot)
                    report_mismatch("slot", m_axis_tdata[97:90], want.slot);
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (!hold_rx) idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // live ids seen in the predictor, for well-formed follow-ups
    logic [63:0] live_ids[$];

    function automatic t_event rand_event();
        t_event e;
        e.kind = 2'($urandom_range(0, 3));
        e.rid = {$urandom, $urandom};
        e.tag = 16'($urandom);
        e.count = 17'($urandom_range(1, 4));
        if ($urandom_range(0, 30) == 0) e.count = 17'($urandom);
        e.code = 8'($urandom);
        e.valid = ($urandom_range(0, 4) != 0);
        e.slot = 8'($urandom);
        return e;
    endfunction

    task automatic push_event(input rst_pkg::t_req k, input logic [63:0] rid,
                              input logic [15:0] tag,
                              input logic [16:0] cnt, input logic [7:0] code,
                              input logic vld, input logic [7:0] slot);
        t_event e;
        e.kind = k; e.rid = rid; e.tag = tag; e.count = cnt;
        e.code = code; e.valid = vld; e.slot = slot;
        pending_events.push_back(e);
    endtask

    task automatic drain_and_idle();
        while (pending_events.size() > 0 || s_axis_tvalid || expected_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == rst_pkg::CFG_CORE) core_reg = val[15:0];
        else seed_reg = val;
        reload_ctr();
    endtask

    logic [63:0] base;
    t_event ev;
    initial begin
        n_errors = 0; hold_rx = 0; hold_tx = 0;
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
        m_axis_tready = 1'b0; i_cfg_we = 1'b0; i_cfg_index = 1'b0; i_cfg_wdata = '0;
        for (int i = 0; i < rst_pkg::PoolDepth; i++) tbl_ident[i] = '0;
        core_reg = '0; seed_reg = '0; reload_ctr();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, add/fail/resp/timeout, special cases
        base = 64'd1 << 48;
        push_event(rst_pkg::REQ_ADD, 0, 16'hFFFF, 17'd2, 0, 0, 0);
        push_event(rst_pkg::REQ_ADD, 0, 16'h0000, 17'd0, 0, 0, 0);
        push_event(rst_pkg::REQ_ADD, 0, 16'h1234, 17'd65536, 0, 0, 0);
        push_event(rst_pkg::REQ_ADD, 0, 16'h1234, 17'd65537, 0, 0, 0);
        push_event(rst_pkg::REQ_ADD, 0, 16'h1234, 17'h1FFFF, 0, 0, 0);
        push_event(rst_pkg::REQ_FAILED, base, 0, 0, 0, 0, 0);
        push_event(rst_pkg::REQ_FAILED, base, 0, 0, 0, 0, 0);
        push_event(rst_pkg::REQ_FAILED, base + 1, 0, 0, 0, 0, 0);
        push_event(rst_pkg::REQ_FAILED, 64'd0, 0, 0, 0, 0, 0);
        push_event(rst_pkg::REQ_RESP, 64'd0, 0, 0, 8'hFF, 1, 0);
        push_event(rst_pkg::REQ_RESP, base + 2, 16'h1235, 0, 8'hFF, 1, 0);
        push_event(rst_pkg::REQ_RESP, base + 2, 16'h1234, 0, 8'hFF, 0, 0);
        push_event(rst_pkg::REQ_RESP, base + 2, 16'h1234, 0, 8'hFF, 1, 0);
        push_event(rst_pkg::REQ_TIMEOUT, '1, 16'hFFFF, 17'h1FFFF, 8'hFF, 1, 8'd2);
        push_event(rst_pkg::REQ_TIMEOUT, 0, 0, 0, 0, 0, 8'hFF);
        push_event(rst_pkg::REQ_TIMEOUT, 0, 0, 0, 0, 0, 8'd3);
        drain_and_idle();

        // zero candidate id: counter seeded to wrap through 0
        write_reg(rst_pkg::CFG_CORE, 32'hFFFF);
        write_reg(rst_pkg::CFG_SEED, 32'd0);
        repeat (3) push_event(rst_pkg::REQ_ADD, 0, 16'h00AA, 17'd1, 0, 0, 0);
        push_event(rst_pkg::REQ_TIMEOUT, 0, 0, 0, 0, 0, 8'hFF);
        drain_and_idle();

        // fill the pool to force the internal error, with a long receiver hold
        write_reg(rst_pkg::CFG_CORE, 32'd0);
        write_reg(rst_pkg::CFG_SEED, 32'd0);
        hold_rx = 1;
        repeat (rst_pkg::PoolDepth + 2)
            push_event(rst_pkg::REQ_ADD, 0, 16'($urandom), 17'd3, 0, 0, 0);
        repeat (600) @(posedge i_clk);
        hold_rx = 0;
        drain_and_idle();
        // free a quarter of the table so random adds can land again
        for (int i = 0; i < 64; i++)
            push_event(rst_pkg::REQ_TIMEOUT, 0, 0, 0, 0, 0, 8'(i));
        drain_and_idle();

        // random phases with several settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(rst_pkg::CFG_CORE, (ph == 3) ? 32'd65534 : 32'($urandom_range(0, 65534)));
            write_reg(rst_pkg::CFG_SEED, (ph == 0) ? 32'd0 : {$urandom});
            for (int n = 0; n < 45; n++) begin
                // follow-ups on live sessions for most non-add items
                live_ids.delete();
                for (int i = 0; i < rst_pkg::PoolDepth; i++)
                    if (tbl_ident[i] != 0) live_ids.push_back(tbl_ident[i]);
                ev = rand_event();
                if (live_ids.size() > 0 && $urandom_range(0, 9) < 6
                    && ev.kind != rst_pkg::REQ_ADD) begin
                    ev.rid = live_ids[$urandom_range(0, live_ids.size() - 1)];
                    ev.slot = ev.rid[7:0];
                    if ($urandom_range(0, 3) != 0) ev.tag = tbl_method[ev.rid[7:0]];
                end
                // pace the items: wait for the driver to take each one from the queue
                pending_events.push_back(ev);
                while (pending_events.size() > 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            if (ph == 1) begin
                hold_tx = 1;
                while (expected_outcomes.size() > 0 || s_axis_tvalid) @(posedge i_clk);
                hold_tx = 0;
            end
            drain_and_idle();
        end

        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
hdl/rst_pkg.sv
hdl/rst_ram.sv
hdl/rpc_session_tracker.sv
sim/tb_rpc_session_tracker.sv
